// ===== hdl/matrix3x3_accumulator_alu_assert.svh =====
// Assertion macros for the 3x3 matrix accumulator ALU
`ifndef MATRIX3X3_ACCUMULATOR_ALU_ASSERT_SVH
`define MATRIX3X3_ACCUMULATOR_ALU_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MXA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("matrix accumulator assertion failed");
`define MXA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("matrix accumulator assertion failed");
`else
`define MXA_ASSERT_SAME(label, clk, rstn, ante, cons)
`define MXA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/mxa_pkg.sv =====
// Shared types and constants for the 3x3 matrix accumulator ALU
package mxa_pkg;

    localparam int MAT_DIM   = 3;
    localparam int NUM_ELEMS = MAT_DIM * MAT_DIM;
    localparam int OP_WIDTH  = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD     = 3'd0,
        OP_ADD      = 3'd1,
        OP_SUBTRACT = 3'd2,
        OP_SCALE    = 3'd3,
        OP_MULTIPLY = 3'd4,
        OP_COMPARE  = 3'd5
    } op_t;

endpackage

// ===== hdl/mxa_lane.sv =====
// One element lane: load, add, subtract, scale and row-by-column dot product with rounding
module mxa_lane #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  mxa_pkg::op_t                                           operation,
    input  logic signed [ELEMENT_WIDTH-1:0]                        a_self,
    input  logic signed [ELEMENT_WIDTH-1:0]                        b_self,
    input  logic signed [ELEMENT_WIDTH-1:0]                        scale,
    input  logic        [mxa_pkg::MAT_DIM-1:0][ELEMENT_WIDTH-1:0]  a_row,
    input  logic        [mxa_pkg::MAT_DIM-1:0][ELEMENT_WIDTH-1:0]  b_col,
    output logic signed [ELEMENT_WIDTH-1:0]                        result
);
    import mxa_pkg::*;

    localparam int PROD_W = 2 * ELEMENT_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [SUM_W-1:0] HALF = (SUM_W'(1) << FRACTION_BITS) >> 1;
    localparam logic signed [ELEMENT_WIDTH-1:0] EL_MAX = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
    localparam logic signed [ELEMENT_WIDTH-1:0] EL_MIN = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

    function automatic logic signed [ELEMENT_WIDTH-1:0] sat_narrow(
        input logic signed [ELEMENT_WIDTH:0] x
    );
        if (x[ELEMENT_WIDTH] != x[ELEMENT_WIDTH-1]) begin
            return x[ELEMENT_WIDTH] ? EL_MIN : EL_MAX;
        end
        return x[ELEMENT_WIDTH-1:0];
    endfunction

    function automatic logic signed [ELEMENT_WIDTH-1:0] round_sat(
        input logic signed [SUM_W-1:0] x
    );
        logic signed [SUM_W-1:0]         biased;
        logic signed [SUM_W-1:0]         shifted;
        logic [SUM_W-ELEMENT_WIDTH:0]    hi;
        biased  = x + $signed(HALF);
        shifted = biased >>> FRACTION_BITS;
        hi      = shifted[SUM_W-1:ELEMENT_WIDTH-1];
        if (hi == '0 || hi == '1) begin
            return shifted[ELEMENT_WIDTH-1:0];
        end
        return shifted[SUM_W-1] ? EL_MIN : EL_MAX;
    endfunction

    logic signed [ELEMENT_WIDTH:0]  add_sum;
    logic signed [ELEMENT_WIDTH:0]  sub_diff;
    logic signed [PROD_W-1:0]       scale_prod;
    logic signed [PROD_W-1:0]       dot_prod [MAT_DIM];
    logic signed [SUM_W-1:0]        dot_sum;

    assign add_sum    = (ELEMENT_WIDTH+1)'(a_self) + (ELEMENT_WIDTH+1)'(b_self);
    assign sub_diff   = (ELEMENT_WIDTH+1)'(a_self) - (ELEMENT_WIDTH+1)'(b_self);
    assign scale_prod = PROD_W'(a_self) * PROD_W'(scale);

    genvar k;
    generate
        for (k = 0; k < MAT_DIM; k++) begin : g_prod
            assign dot_prod[k] = PROD_W'($signed(a_row[k])) * PROD_W'($signed(b_col[k]));
        end
    endgenerate

    assign dot_sum = SUM_W'(dot_prod[0]) + SUM_W'(dot_prod[1]) + SUM_W'(dot_prod[2]);

    always_comb begin
        case (operation)
            OP_LOAD:     result = b_self;
            OP_ADD:      result = sat_narrow(add_sum);
            OP_SUBTRACT: result = sat_narrow(sub_diff);
            OP_SCALE:    result = round_sat(SUM_W'(scale_prod));
            OP_MULTIPLY: result = round_sat(dot_sum);
            default:     result = a_self;
        endcase
    end

endmodule

// ===== hdl/matrix3x3_accumulator_alu.sv =====
// Top level of the 3x3 matrix accumulator ALU: input register, nine lanes, result register
//
// Input channel (s_*): one transfer carries an operation, a 3x3 operand matrix, a scalar
// and a write-back bit. Result channel (m_*): one transfer per input item, carrying the
// result matrix and the equal flag (accumulator before the item equals the operand).
// Operations: load, add, subtract, scale, multiply (accumulator times operand), compare.
// With write-back set, every operation but compare and the two unused codes replaces
// the accumulator.
// An accepted item waits in the input register and moves to the result register,
// raising m_valid, once that register is empty or its transfer is being taken.
// Throughput: one item per cycle while m_ready is high; nine lanes, each with three
// multipliers feeding one rounding adder, finish an item between the input and result
// registers, and the accumulator is written in the same cycle so the next item sees it.
// Reset clears the accumulator to zero and empties both register stages.
// When the receiver stalls, the result register holds its transfer, the input register
// keeps one more item, and s_ready then drops until m_ready returns.
`include "matrix3x3_accumulator_alu_assert.svh"

module matrix3x3_accumulator_alu #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mxa_pkg::OP_WIDTH-1:0]        s_operation,
    input  logic                                s_write_back,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_scale_factor,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r0c0,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r0c1,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r0c2,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r1c0,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r1c1,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r1c2,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r2c0,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r2c1,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_operand_r2c2,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r0c0,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r0c1,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r0c2,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r1c0,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r1c1,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r1c2,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r2c0,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r2c1,
    output logic signed [ELEMENT_WIDTH-1:0]     m_result_r2c2,
    output logic                                m_equal_flag
);
    import mxa_pkg::*;

    typedef logic [NUM_ELEMS-1:0][ELEMENT_WIDTH-1:0] matrix_t;

    logic     in_valid_reg;
    logic     in_valid_next;
    op_t      op_reg;
    logic     wb_reg;
    logic     [ELEMENT_WIDTH-1:0] scale_reg;
    matrix_t  opnd_reg;

    matrix_t  acc_reg;
    matrix_t  acc_next;

    logic     out_valid_reg;
    logic     out_valid_next;
    matrix_t  result_reg;
    logic     equal_reg;

    matrix_t  lane_result;
    logic     equal_now;
    logic     advance;
    logic     fire;
    logic     s_take;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_valid_next  = s_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    assign equal_now      = (acc_reg == opnd_reg);

    always_comb begin
        acc_next = acc_reg;
        if (fire && wb_reg) begin
            case (op_reg)
                OP_LOAD, OP_ADD, OP_SUBTRACT, OP_SCALE, OP_MULTIPLY: acc_next = lane_result;
                default: acc_next = acc_reg;
            endcase
        end
    end

    genvar i, k;
    generate
        for (i = 0; i < NUM_ELEMS; i++) begin : g_lane
            localparam int ROW = i / MAT_DIM;
            localparam int COL = i % MAT_DIM;
            logic [MAT_DIM-1:0][ELEMENT_WIDTH-1:0] a_row;
            logic [MAT_DIM-1:0][ELEMENT_WIDTH-1:0] b_col;
            logic signed [ELEMENT_WIDTH-1:0]       lane_out;

            for (k = 0; k < MAT_DIM; k++) begin : g_tap
                assign a_row[k] = acc_reg[ROW * MAT_DIM + k];
                assign b_col[k] = opnd_reg[k * MAT_DIM + COL];
            end

            mxa_lane #(
                .ELEMENT_WIDTH (ELEMENT_WIDTH),
                .FRACTION_BITS (FRACTION_BITS)
            ) u_lane (
                .operation (op_reg),
                .a_self    ($signed(acc_reg[i])),
                .b_self    ($signed(opnd_reg[i])),
                .scale     ($signed(scale_reg)),
                .a_row     (a_row),
                .b_col     (b_col),
                .result    (lane_out)
            );

            assign lane_result[i] = lane_out;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            op_reg      <= op_t'(s_operation);
            wb_reg      <= s_write_back;
            scale_reg   <= s_scale_factor;
            opnd_reg[0] <= s_operand_r0c0;
            opnd_reg[1] <= s_operand_r0c1;
            opnd_reg[2] <= s_operand_r0c2;
            opnd_reg[3] <= s_operand_r1c0;
            opnd_reg[4] <= s_operand_r1c1;
            opnd_reg[5] <= s_operand_r1c2;
            opnd_reg[6] <= s_operand_r2c0;
            opnd_reg[7] <= s_operand_r2c1;
            opnd_reg[8] <= s_operand_r2c2;
        end
        if (fire) begin
            result_reg <= lane_result;
            equal_reg  <= equal_now;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_equal_flag  = equal_reg;
    assign m_result_r0c0 = $signed(result_reg[0]);
    assign m_result_r0c1 = $signed(result_reg[1]);
    assign m_result_r0c2 = $signed(result_reg[2]);
    assign m_result_r1c0 = $signed(result_reg[3]);
    assign m_result_r1c1 = $signed(result_reg[4]);
    assign m_result_r1c2 = $signed(result_reg[5]);
    assign m_result_r2c0 = $signed(result_reg[6]);
    assign m_result_r2c1 = $signed(result_reg[7]);
    assign m_result_r2c2 = $signed(result_reg[8]);

    `MXA_ASSERT_NEXT(a_acc_hold_idle, aclk, aresetn, !fire, $stable(acc_reg))
    `MXA_ASSERT_NEXT(a_acc_hold_compare, aclk, aresetn, fire && op_reg == OP_COMPARE, $stable(acc_reg))
    `MXA_ASSERT_NEXT(a_load_writes_acc, aclk, aresetn, fire && wb_reg && op_reg == OP_LOAD, acc_reg == result_reg)
    `MXA_ASSERT_SAME(a_no_overrun, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready)

endmodule
